/* src/wlhc_pkg.sv */
`timescale 1ns / 1ps

package wlhc_pkg;

  // Input request: one byte of the file, with the file length on the first byte.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [31:0] file_length;
  } in_req_t;

  // Verdict on the lossy header.
  typedef struct packed {
    logic        header_ok;
    logic [3:0]  status;
    logic [13:0] frame_width;
    logic [13:0] frame_height;
    logic [4:0]  payload_offset;
  } out_rsp_t;

  // Verdict status codes.
  localparam logic [3:0] ST_OK            = 4'd0;
  localparam logic [3:0] ST_BAD_WEBP      = 4'd1;
  localparam logic [3:0] ST_RIFF_SMALL    = 4'd2;
  localparam logic [3:0] ST_NOT_VP8       = 4'd3;
  localparam logic [3:0] ST_CHUNK_BIG     = 4'd4;
  localparam logic [3:0] ST_CHUNK_ZERO    = 4'd5;
  localparam logic [3:0] ST_SHORT         = 4'd6;
  localparam logic [3:0] ST_BAD_START     = 4'd7;
  localparam logic [3:0] ST_NOT_KEY       = 4'd8;
  localparam logic [3:0] ST_PROFILE       = 4'd9;
  localparam logic [3:0] ST_INVISIBLE     = 4'd10;
  localparam logic [3:0] ST_PARTITION     = 4'd11;

  // Bit positions in the tag match flags.
  localparam int FLAG_RIFF  = 0;
  localparam int FLAG_START = 1;
  localparam int FLAG_WEBP  = 2;
  localparam int FLAG_VP8   = 3;

  // Length and size limits.
  localparam logic [31:0] MIN_FILE_LEN      = 32'd10;
  localparam logic [31:0] MIN_CONTAINER_LEN = 32'd30;
  localparam logic [31:0] MIN_RIFF_SIZE     = 32'd12;
  localparam logic [4:0]  FRAME_OFFSET      = 5'd20;
  localparam logic [4:0]  LAST_POSITION     = 5'd31;

  // "RIFF"
  function automatic logic [7:0] riff_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = 8'h52;
      2'd1: c = 8'h49;
      2'd2: c = 8'h46;
      default: c = 8'h46;
    endcase
    return c;
  endfunction

  // "WEBP"
  function automatic logic [7:0] webp_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = 8'h57;
      2'd1: c = 8'h45;
      2'd2: c = 8'h42;
      default: c = 8'h50;
    endcase
    return c;
  endfunction

  // "VP8 "
  function automatic logic [7:0] vp8_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = 8'h56;
      2'd1: c = 8'h50;
      2'd2: c = 8'h38;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

  // Frame start code 9d 01 2a, indexed by frame byte 3, 4 and 5.
  function automatic logic [7:0] start_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = 8'h9d;
      2'd1: c = 8'h01;
      default: c = 8'h2a;
    endcase
    return c;
  endfunction

endpackage

/* src/webp_lossy_header_check.sv */
`timescale 1ns / 1ps

// Channel  Handshake            Payload    Direction
// in       in_valid / in_stall  in_req     file bytes into the block
// out      out_valid / out_stall out_rsp   one verdict per file
//
// One byte is taken every cycle unless the input side stalls; a verdict leaves
// through the input register, the parse logic and the output register.
// Reset is synchronous and active low; it leaves the block waiting for a first byte.
// A stalled verdict holds in the output register; the input side stalls only when the
// byte in the input register would give a verdict and the output register is full and stalled.
// Bytes that give no verdict keep flowing while a verdict waits.
module webp_lossy_header_check
  import wlhc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_rsp
);

  // Input register.
  logic    in_valid_r;
  in_req_t in_req_r;

  // Parse state.
  logic [4:0]  byte_pos_r,   byte_pos_nxt;
  logic        container_r,  container_nxt;
  logic [31:0] length_r,     length_nxt;
  logic [31:0] riff_size_r,  riff_size_nxt;
  logic [31:0] chunk_size_r, chunk_size_nxt;
  logic [23:0] frame_tag_r,  frame_tag_nxt;
  logic [3:0]  tag_flags_r,  tag_flags_nxt;
  logic [7:0]  width_lo_r,   width_lo_nxt;
  logic [7:0]  height_lo_r,  height_lo_nxt;
  logic        verdict_r,    verdict_nxt;

  // Output register.
  logic     out_valid_r;
  out_rsp_t out_rsp_r;

  // Result of the byte in the input register.
  logic        res_valid;
  logic [3:0]  res_status;
  logic [13:0] res_width;
  logic [13:0] res_height;
  logic [4:0]  pos;
  logic [4:0]  frame_pos;
  logic [7:0]  b;
  logic        advance;

  assign b = in_req_r.data_byte;

  // The byte moves on unless it gives a verdict and the output register is blocked.
  assign advance  = !res_valid || !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;

  // Parse one byte against the current state.
  always_comb begin
    byte_pos_nxt   = byte_pos_r;
    container_nxt  = container_r;
    length_nxt     = length_r;
    riff_size_nxt  = riff_size_r;
    chunk_size_nxt = chunk_size_r;
    frame_tag_nxt  = frame_tag_r;
    tag_flags_nxt  = tag_flags_r;
    width_lo_nxt   = width_lo_r;
    height_lo_nxt  = height_lo_r;
    verdict_nxt    = verdict_r;
    res_valid      = 1'b0;
    res_status     = ST_OK;
    res_width      = '0;
    res_height     = '0;
    pos            = '0;
    frame_pos      = '0;

    // A first byte restarts the parse; a very short file is rejected at once.
    if (in_req_r.first_byte) begin
      byte_pos_nxt   = '0;
      container_nxt  = 1'b0;
      length_nxt     = in_req_r.file_length;
      riff_size_nxt  = '0;
      chunk_size_nxt = in_req_r.file_length;
      frame_tag_nxt  = '0;
      tag_flags_nxt  = '1;
      width_lo_nxt   = '0;
      height_lo_nxt  = '0;
      verdict_nxt    = 1'b0;
      if (in_req_r.file_length < MIN_FILE_LEN) begin
        res_valid   = 1'b1;
        res_status  = (in_req_r.file_length == '0) ? ST_CHUNK_ZERO : ST_SHORT;
        verdict_nxt = 1'b1;
      end
    end

    if (!verdict_nxt) begin
      pos = byte_pos_nxt;
      if (pos != LAST_POSITION) begin
        byte_pos_nxt = pos + 5'd1;
      end

      // The RIFF prefix decides whether a container follows.
      if (pos < 5'd4) begin
        if (b != riff_char(pos[1:0])) begin
          tag_flags_nxt[FLAG_RIFF] = 1'b0;
        end
        if (pos == 5'd3 && tag_flags_nxt[FLAG_RIFF] && length_nxt >= MIN_CONTAINER_LEN) begin
          container_nxt = 1'b1;
        end
      end

      if (container_nxt && pos < FRAME_OFFSET) begin
        // Container header: RIFF size, WEBP tag, VP8 tag, chunk size.
        if (pos >= 5'd4 && pos < 5'd8) begin
          riff_size_nxt[{pos[1:0], 3'b000} +: 8] = b;
        end else if (pos >= 5'd8 && pos < 5'd12) begin
          if (b != webp_char(pos[1:0])) begin
            tag_flags_nxt[FLAG_WEBP] = 1'b0;
          end
          if (pos == 5'd11) begin
            if (!tag_flags_nxt[FLAG_WEBP]) begin
              res_valid  = 1'b1;
              res_status = ST_BAD_WEBP;
            end else if (riff_size_nxt < MIN_RIFF_SIZE) begin
              res_valid  = 1'b1;
              res_status = ST_RIFF_SMALL;
            end
          end
        end else if (pos >= 5'd12 && pos < 5'd16) begin
          if (b != vp8_char(pos[1:0])) begin
            tag_flags_nxt[FLAG_VP8] = 1'b0;
          end
          if (pos == 5'd15 && !tag_flags_nxt[FLAG_VP8]) begin
            res_valid  = 1'b1;
            res_status = ST_NOT_VP8;
          end
        end else if (pos >= 5'd16) begin
          chunk_size_nxt[{pos[1:0], 3'b000} +: 8] = b;
          if (pos == 5'd19) begin
            // The RIFF size is at least 12 here, so this matches size - 12.
            if ({1'b0, chunk_size_nxt} + {1'b0, MIN_RIFF_SIZE} > {1'b0, riff_size_nxt}) begin
              res_valid  = 1'b1;
              res_status = ST_CHUNK_BIG;
            end else if (chunk_size_nxt == '0) begin
              res_valid  = 1'b1;
              res_status = ST_CHUNK_ZERO;
            end
          end
        end
      end else begin
        // VP8 frame: tag, start code, width and height.
        frame_pos = container_nxt ? pos - FRAME_OFFSET : pos;
        if (frame_pos < 5'd3) begin
          frame_tag_nxt[{frame_pos[1:0], 3'b000} +: 8] = b;
        end else if (frame_pos < 5'd6) begin
          if (b != start_char(2'(frame_pos - 5'd3))) begin
            tag_flags_nxt[FLAG_START] = 1'b0;
          end
          if (frame_pos == 5'd5) begin
            res_valid = 1'b1;
            priority if (!tag_flags_nxt[FLAG_START]) begin
              res_status = ST_BAD_START;
            end else if (frame_tag_nxt[0]) begin
              res_status = ST_NOT_KEY;
            end else if (frame_tag_nxt[3:1] > 3'd3) begin
              res_status = ST_PROFILE;
            end else if (!frame_tag_nxt[4]) begin
              res_status = ST_INVISIBLE;
            end else if ({13'b0, frame_tag_nxt[23:5]} >= chunk_size_nxt) begin
              res_status = ST_PARTITION;
            end else begin
              res_valid = 1'b0;
            end
          end
        end else if (frame_pos == 5'd6) begin
          width_lo_nxt = b;
        end else if (frame_pos == 5'd7) begin
          // The chunk size is no longer needed; it now holds the width.
          chunk_size_nxt = {18'b0, b[5:0], width_lo_nxt};
        end else if (frame_pos == 5'd8) begin
          height_lo_nxt = b;
        end else if (frame_pos == 5'd9) begin
          res_valid  = 1'b1;
          res_status = ST_OK;
          res_width  = chunk_size_nxt[13:0];
          res_height = {b[5:0], height_lo_nxt};
        end
      end

      if (res_valid) begin
        verdict_nxt = 1'b1;
      end
    end
  end

  // Input register, parse state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      byte_pos_r   <= '0;
      container_r  <= 1'b0;
      length_r     <= '0;
      riff_size_r  <= '0;
      chunk_size_r <= '0;
      frame_tag_r  <= '0;
      tag_flags_r  <= '1;
      width_lo_r   <= '0;
      height_lo_r  <= '0;
      verdict_r    <= 1'b1;
    end else begin
      if (in_valid && !in_stall) begin
        in_valid_r <= 1'b1;
        in_req_r   <= in_req;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end

      if (in_valid_r && advance) begin
        byte_pos_r   <= byte_pos_nxt;
        container_r  <= container_nxt;
        length_r     <= length_nxt;
        riff_size_r  <= riff_size_nxt;
        chunk_size_r <= chunk_size_nxt;
        frame_tag_r  <= frame_tag_nxt;
        tag_flags_r  <= tag_flags_nxt;
        width_lo_r   <= width_lo_nxt;
        height_lo_r  <= height_lo_nxt;
        verdict_r    <= verdict_nxt;
      end

      if (in_valid_r && advance && res_valid) begin
        out_valid_r                <= 1'b1;
        out_rsp_r.header_ok        <= (res_status == ST_OK);
        out_rsp_r.status           <= res_status;
        out_rsp_r.frame_width      <= (res_status == ST_OK) ? res_width : '0;
        out_rsp_r.frame_height     <= (res_status == ST_OK) ? res_height : '0;
        out_rsp_r.payload_offset   <= container_nxt ? FRAME_OFFSET : '0;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

`ifndef SYNTH
  // The accept flag agrees with the status code.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rsp_r.header_ok == (out_rsp_r.status == ST_OK)))
    else $error("header_ok disagrees with status");

  // A rejected header reports no picture size.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp_r.header_ok) |->
      (out_rsp_r.frame_width == '0 && out_rsp_r.frame_height == '0))
    else $error("rejected header carries a picture size");

  // The frame starts either at the file start or right after the container header.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_rsp_r.payload_offset == '0 ||
                     out_rsp_r.payload_offset == FRAME_OFFSET))
    else $error("bad payload offset");

  // Once a verdict is issued, the file's later bytes give no second one.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && advance && res_valid) |=> verdict_r)
    else $error("verdict not recorded");

  // A verdict that cannot leave holds the input side.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && res_valid && out_valid_r && out_stall) |-> in_stall)
    else $error("verdict would overwrite a waiting result");
`endif

endmodule
